// ----- sv/rsks_pkg.sv -----
// Shared types and constants for the record stack with key search.
package rsks_pkg;

    // Field widths of one word on each side
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned OUT_D_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the accepted input word
        logic emit;       // finish the operation and fill the output register
        logic pop_rd;     // drop the top entry and read it
        logic scan_init;  // rewind the search pointer
        logic scan_step;  // issue the next search read
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_op  op;         // captured operation
        logic empty;      // no entries held
        logic hit;        // last search read matches the key
        logic scan_end;   // every held entry has been read
        logic pend;       // a search read is in flight
        logic out_free;   // output register can take a word this cycle
    } t_sts;

endpackage

// ----- sv/record_stack_with_key_search.sv -----
// Top level of the bounded LIFO key stack with bottom-up linear search.
//
//  Channel   Direction  tdata (low bit up)                       tuser
//  s_axis    in         key[31:0]                                operation[1:0]
//  m_axis    out        popped_key[31:0], found_position[38:32], status[1:0]
//                       stack_empty[39], stack_full[40], zero[47:41]
//
//  One word is worked on at a time: push and unused codes are loaded and emitted, a pop
//  also reads the top entry, and a search reads the held entries from the bottom up,
//  paced by the single read port of the entry memory (one entry a cycle).
//  The output register holds one result, so a new word is accepted while it waits.
//  A stalled output stalls completion only. Reset (synchronous) empties the stack.
module record_stack_with_key_search
    import rsks_pkg::*;
#(
    parameter int unsigned DEPTH = 128
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [KEY_W-1:0]   s_axis_tdata,   // key
    input  logic [OP_W-1:0]    s_axis_tuser,   // operation
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_D_W-1:0] m_axis_tdata,   // popped_key, found_position, empty, full
    output logic [ST_W-1:0]    m_axis_tuser    // status
);

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [KEY_W-1:0] w_popped;
    logic [POS_W-1:0] w_found;
    logic             w_empty;
    logic             w_full;

    rsks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rsks_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_op             (s_axis_tuser),
        .i_key            (s_axis_tdata),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_status         (m_axis_tuser),
        .o_popped_key     (w_popped),
        .o_found_position (w_found),
        .o_stack_empty    (w_empty),
        .o_stack_full     (w_full)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {{(OUT_D_W-KEY_W-POS_W-2){1'b0}}, w_full, w_empty, w_found, w_popped};

endmodule

// ----- sv/rsks_ctrl.sv -----
// Controller state machine for the record stack with key search.
module rsks_ctrl
    import rsks_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POPW = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_fin;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_fin      = i_sts.hit || (i_sts.scan_end && !i_sts.pend);

    // Sequence each operation and hold on a busy output register
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_POP: begin
                        if (!i_sts.empty) begin
                            o_cmd.pop_rd = 1'b1;
                            n_state      = S_POPW;
                        end else if (i_sts.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    OP_SEARCH: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            S_POPW: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!w_fin) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/rsks_dp.sv -----
// Datapath: entry memory, fill count, search pointer and output register.
module rsks_dp
    import rsks_pkg::*;
#(
    parameter int unsigned DEPTH = 128
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [OP_W-1:0]     i_op,
    input  logic [KEY_W-1:0]    i_key,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ST_W-1:0]     o_status,
    output logic [KEY_W-1:0]    o_popped_key,
    output logic [POS_W-1:0]    o_found_position,
    output logic                o_stack_empty,
    output logic                o_stack_full
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = $clog2(DEPTH);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rd_data;

    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    n_idx;
    logic             r_pend;
    logic             n_pend;
    logic [AW-1:0]    r_pos;
    logic [AW-1:0]    n_pos;
    logic             r_pop_ok;
    logic             r_out_vld;
    logic             n_out_vld;

    logic             w_full;
    logic             w_empty;
    logic             w_hit;
    logic             w_we;
    logic             w_re;
    logic [AW-1:0]    w_ra;
    logic [CW-1:0]    w_cnt_dec;
    logic [POS_W+AW-1:0] w_pos_ext;

    logic [ST_W-1:0]  r_status;
    logic [ST_W-1:0]  n_status;
    logic [KEY_W-1:0] r_popped;
    logic [KEY_W-1:0] n_popped;
    logic [POS_W-1:0] r_found;
    logic [POS_W-1:0] n_found;
    logic             r_s_empty;
    logic             r_s_full;

    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_hit     = r_pend && (r_rd_data == r_key);
    assign w_cnt_dec = r_count - CW'(1);
    assign w_pos_ext = {{POS_W{1'b0}}, r_pos};

    assign o_sts.op       = r_op;
    assign o_sts.empty    = w_empty;
    assign o_sts.hit      = w_hit;
    assign o_sts.scan_end = (r_idx == r_count);
    assign o_sts.pend     = r_pend;
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    // Advance the fill count and the search pointer, drive the memory port
    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_pos   = r_pos;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_ra    = r_idx[AW-1:0];
        if (i_cmd.emit && (r_op == OP_PUSH) && !w_full) begin
            w_we    = 1'b1;
            n_count = r_count + CW'(1);
        end
        if (i_cmd.pop_rd) begin
            n_count = w_cnt_dec;
            w_re    = 1'b1;
            w_ra    = w_cnt_dec[AW-1:0];
        end
        if (i_cmd.scan_init) begin
            n_idx  = '0;
            n_pend = 1'b0;
        end
        if (i_cmd.scan_step) begin
            if (r_idx != r_count) begin
                w_re   = 1'b1;
                n_pend = 1'b1;
                n_pos  = r_idx[AW-1:0];
                n_idx  = r_idx + CW'(1);
            end else begin
                n_pend = 1'b0;
            end
        end
    end

    // Build the result word of the finished operation
    always_comb begin
        n_status = ST_OK;
        n_popped = '0;
        n_found  = '0;
        case (r_op)
            OP_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end
            end
            OP_POP: begin
                if (r_pop_ok) begin
                    n_popped = r_rd_data;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            OP_SEARCH: begin
                if (w_hit) begin
                    n_found = w_pos_ext[POS_W-1:0];
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Set the output valid on emit, drop it once the word is taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (i_cmd.emit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // Entry memory with registered read data
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[AW-1:0]] <= r_key;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_key    <= i_key;
            r_pop_ok <= 1'b0;
        end else if (i_cmd.pop_rd) begin
            r_pop_ok <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_status  <= n_status;
            r_popped  <= n_popped;
            r_found   <= n_found;
            r_s_empty <= (n_count == '0);
            r_s_full  <= (n_count == CW'(DEPTH));
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_status;
    assign o_popped_key     = r_popped;
    assign o_found_position = r_found;
    assign o_stack_empty    = r_s_empty;
    assign o_stack_full     = r_s_full;

endmodule

// ----- tb/sv/key_stack_checker.sv -----
// Checker for the key stack: predicts each result word and compares it with the output channel.
`timescale 1ns / 100ps
module key_stack_checker
    import rsks_pkg::*;
#(
    parameter int unsigned DEPTH = 128
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [KEY_W-1:0]   i_in_key,
    input  logic [OP_W-1:0]    i_in_op,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [OUT_D_W-1:0] i_out_data,
    input  logic [ST_W-1:0]    i_out_status,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending
);

    localparam int unsigned PAD_W = OUT_D_W - KEY_W - POS_W - 2;
    localparam int unsigned MAX_REPORTS = 10;

    // One result word split into its fields
    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   popped_key;
        logic [POS_W-1:0]   found_pos;
        logic               empty;
        logic               full;
        logic [PAD_W-1:0]   pad;
    } t_stack_result;

    // Shadow copy of the stack contents
    logic [KEY_W-1:0] stored_keys [DEPTH];
    int unsigned      held_count;

    t_stack_result    expected_results [$];
    int unsigned      fail_count;
    int unsigned      reports;

    // Apply one operation to the shadow stack and return the result it must produce
    function automatic t_stack_result apply_stack_op(input t_op op, input logic [KEY_W-1:0] key);
        t_stack_result res;
        logic          hit;
        int unsigned   i;
        res = '0;
        res.status = ST_OK;
        hit = 1'b0;
        case (op)
            OP_PUSH: begin
                if (held_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stored_keys[held_count] = key;
                    held_count++;
                end
            end
            OP_POP: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    held_count--;
                    res.popped_key = stored_keys[held_count];
                end
            end
            OP_SEARCH: begin
                // scan bottom up, keep the first match only
                for (i = 0; i < held_count && !hit; i++) begin
                    if (stored_keys[i] == key) begin
                        hit = 1'b1;
                        res.found_pos = i[POS_W-1:0];
                    end
                end
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        res.empty = (held_count == 0);
        res.full  = (held_count >= DEPTH);
        return res;
    endfunction

    // Compare accepted results first, then queue the prediction for an accepted input word
    always @(posedge i_clk) begin
        t_stack_result actual;
        t_stack_result want;
        if (!i_rst_n) begin
            held_count = 0;
            expected_results.delete();
            fail_count = 0;
            reports = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                actual.status     = t_status'(i_out_status);
                actual.popped_key = i_out_data[KEY_W-1:0];
                actual.found_pos  = i_out_data[KEY_W+POS_W-1:KEY_W];
                actual.empty      = i_out_data[KEY_W+POS_W];
                actual.full       = i_out_data[KEY_W+POS_W+1];
                actual.pad        = i_out_data[OUT_D_W-1:KEY_W+POS_W+2];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("%0t: result word with nothing expected: status %0d key %h",
                                 $time, actual.status, actual.popped_key);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (actual !== want) begin
                        fail_count++;
                        if (reports < MAX_REPORTS) begin
                            reports++;
                            $display("%0t: mismatch, expected st %0d key %h pos %0d e %b f %b pad %h",
                                     $time, want.status, want.popped_key, want.found_pos,
                                     want.empty, want.full, want.pad);
                            $display("%0t:           got      st %0d key %h pos %0d e %b f %b pad %h",
                                     $time, actual.status, actual.popped_key, actual.found_pos,
                                     actual.empty, actual.full, actual.pad);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_stack_op(t_op'(i_in_op), i_in_key));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

// ----- tb/sv/record_stack_with_key_search_tb.sv -----
// Testbench top for the key stack: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module record_stack_with_key_search_tb;
    import rsks_pkg::*;

    localparam int unsigned STACK_DEPTH   = 128;
    localparam int unsigned RANDOM_WORDS  = 800;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    // longest search plus the output register
    localparam int unsigned SETTLE_CYCLES = STACK_DEPTH + 8;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [KEY_W-1:0]   s_axis_tdata = '0;   // key
    logic [OP_W-1:0]    s_axis_tuser = OP_NONE;   // operation
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_D_W-1:0] m_axis_tdata;   // popped_key, found_position, empty, full, zero
    logic [ST_W-1:0]    m_axis_tuser;   // status

    int unsigned        fail_count;
    int unsigned        pending;
    int unsigned        cycle_count = 0;
    int unsigned        stall_left = 0;
    logic               quiet = 1'b0;

    // Stimulus-side bookkeeping: keys currently held, and what was covered
    logic [KEY_W-1:0]   held_keys [$];
    int unsigned        n_push = 0;
    int unsigned        n_pop = 0;
    int unsigned        n_search = 0;
    int unsigned        n_unused = 0;
    int unsigned        n_full_refused = 0;
    int unsigned        n_empty_refused = 0;
    int unsigned        peak_depth = 0;

    logic [KEY_W-1:0]   key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'h0000_0001, 32'hAAAA_5555,
                                         32'h1234_5678, 32'h0F0F_F0F0};

    record_stack_with_key_search #(
        .DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    key_stack_checker #(
        .DEPTH(STACK_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_key     (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_status (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Stall the output channel at random unless in a quiet phase
    always @(posedge clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rst_n && !quiet && $urandom_range(0, 99) < 20) begin
            m_axis_tready <= 1'b0;
            stall_left <= idle_length() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic t_op pick_op(input t_mix mix);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return (r < 80) ? OP_PUSH : (r < 92) ? OP_SEARCH :
                              (r < 97) ? OP_POP : OP_NONE;
            MIX_DRAIN: return (r < 70) ? OP_POP : (r < 88) ? OP_SEARCH :
                              (r < 96) ? OP_PUSH : OP_NONE;
            default:   return (r < 38) ? OP_PUSH : (r < 70) ? OP_POP :
                              (r < 95) ? OP_SEARCH : OP_NONE;
        endcase
    endfunction

    // Searches favor keys that are held so hits land at every depth
    function automatic logic [KEY_W-1:0] pick_key(input t_op op);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (op == OP_SEARCH && held_keys.size() != 0 && r < 55) begin
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
        end
        if (r >= 75) begin
            return key_pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    // Present one word, hold it until accepted, and track the stack it leaves behind
    task automatic send_word(input t_op op, input logic [KEY_W-1:0] key);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 99) < 35) ? idle_length() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        case (op)
            OP_PUSH: begin
                n_push++;
                if (held_keys.size() < STACK_DEPTH) begin
                    held_keys.push_back(key);
                end else begin
                    n_full_refused++;
                end
            end
            OP_POP: begin
                n_pop++;
                if (held_keys.size() != 0) begin
                    void'(held_keys.pop_back());
                end else begin
                    n_empty_refused++;
                end
            end
            OP_SEARCH: n_search++;
            default:   n_unused++;
        endcase
        if (held_keys.size() > peak_depth) begin
            peak_depth = held_keys.size();
        end
    endtask

    // Hold off the input until every result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned phase_idx;
        int unsigned phase_len;
        int unsigned n;
        t_mix        mix;
        t_op         op;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: refusals on empty, unused code, extreme keys, duplicates, LIFO order
        send_word(OP_POP,    32'h0000_0000);
        send_word(OP_SEARCH, 32'h0000_0000);
        send_word(OP_NONE,   32'hFFFF_FFFF);
        send_word(OP_PUSH,   32'h8000_0000);
        send_word(OP_PUSH,   32'h7FFF_FFFF);
        send_word(OP_PUSH,   32'h0000_0000);
        send_word(OP_PUSH,   32'hFFFF_FFFF);
        send_word(OP_PUSH,   32'h7FFF_FFFF);
        send_word(OP_SEARCH, 32'h7FFF_FFFF);
        send_word(OP_SEARCH, 32'h8000_0000);
        send_word(OP_SEARCH, 32'hFFFF_FFFF);
        send_word(OP_SEARCH, 32'h0000_0000);
        send_word(OP_SEARCH, 32'h1234_5678);
        send_word(OP_NONE,   32'h5555_5555);
        repeat (5) send_word(OP_POP, 32'hFFFF_FFFF);
        send_word(OP_POP,    32'h0000_0000);
        send_word(OP_SEARCH, 32'h7FFF_FFFF);
        drain_results();

        // Random phases; the first one fills the stack past full
        random_sent = 0;
        phase_idx = 0;
        while (random_sent < RANDOM_WORDS) begin
            mix = (phase_idx == 0) ? MIX_FILL : t_mix'($urandom_range(0, 2));
            phase_len = (phase_idx == 0) ? 200 : $urandom_range(40, 160);
            quiet = (phase_idx != 0) && ($urandom_range(0, 3) == 0);
            for (n = 0; n < phase_len && random_sent < RANDOM_WORDS; n++) begin
                op = pick_op(mix);
                send_word(op, pick_key(op));
                if (op != OP_NONE) begin
                    random_sent++;
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                drain_results();
            end
            phase_idx++;
        end

        quiet = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d push, %0d pop, %0d search and %0d unused-code words;",
                 n_push, n_pop, n_search, n_unused);
        $display("deepest %0d of %0d, refused %0d pushes on full and %0d pops on empty.",
                 peak_depth, STACK_DEPTH, n_full_refused, n_empty_refused);
        $display("%0d results wrong or unexpected.", fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
